[rtl/keyed_shuffle_permuter_assert.svh]
// Assertion macros for the keyed shuffle permuter.
// Used by rtl/keyed_shuffle_permuter.sv; no other dependencies.
`ifndef KEYED_SHUFFLE_PERMUTER_ASSERT_SVH
`define KEYED_SHUFFLE_PERMUTER_ASSERT_SVH

// hold: condition implies consequence in the same cycle
`define KSP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// hold: condition implies consequence in the next cycle
`define KSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ksp_pkg.sv]
// Types and constants for the keyed shuffle permuter.
// No dependencies.
`default_nettype none

package ksp_pkg;

    localparam int DATA_W      = 8;
    localparam int ADDR_W      = 6;
    localparam int STORE_DEPTH = 64;
    localparam int CNT_W       = ADDR_W + 1;
    localparam int LCG_W       = 32;
    localparam int BIT_CNT_W   = $clog2(LCG_W);
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [DATA_W-1:0] byte_t;
    typedef logic [LCG_W-1:0]  lcg_t;

    localparam lcg_t LCG_MUL = 32'd1664525;
    localparam lcg_t LCG_ADD = 32'd1013904223;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b1;

    localparam logic MODE_SCRAMBLE   = 1'b0;
    localparam logic MODE_UNSCRAMBLE = 1'b1;

endpackage

`default_nettype wire

[rtl/keyed_shuffle_permuter.sv]
// Keyed shuffle permuter: collects a byte block, shuffles a permutation with an LCG,
// and emits the block scrambled or unscrambled. Depends on ksp_pkg and
// keyed_shuffle_permuter_assert.svh.
//
//  port group | dir | words                        | handshake
//  s_axis     | in  | tdata[7:0] data_in, tlast    | tvalid/tready
//  m_axis     | out | tdata[7:0], tlast, tuser ovf | tvalid/tready
//  cfg        | in  | index 0 seed, 1 mode         | cfg_we, no wait
//
// A block of n words is taken at one word per cycle, then the permutation is built:
// an identity fill, then per swap step an LCG multiply and add, the bit-serial
// remainder unit and two reads and two writes. Mapping reads the permutation
// and moves each word; emission reads each word and waits out any stall on m_axis_tready.
// Reset clears control state only; the stores need no clearing pass.
// Input is taken only while collecting; output stalls hold the block.
`default_nettype none

module keyed_shuffle_permuter #(
    parameter int MAX_LEN = 64
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire  [ksp_pkg::DATA_W-1:0]      s_axis_tdata,   // [7:0] data_in
    input  wire                             s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  wire                             m_axis_tready,
    output logic [ksp_pkg::DATA_W-1:0]      m_axis_tdata,   // [7:0] data_out
    output logic                            m_axis_tlast,
    output logic                            m_axis_tuser,   // [0] overflow
    input  wire                             cfg_we,
    input  wire  [ksp_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire  [ksp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ksp_pkg::*;

    `include "keyed_shuffle_permuter_assert.svh"

    localparam int DIV_W = ADDR_W + 1;
    localparam int ST_W  = 4;

    localparam logic [ST_W-1:0] S_LOAD = 4'd0;
    localparam logic [ST_W-1:0] S_INIT = 4'd1;
    localparam logic [ST_W-1:0] S_MUL  = 4'd2;
    localparam logic [ST_W-1:0] S_ADD  = 4'd3;
    localparam logic [ST_W-1:0] S_DIV  = 4'd4;
    localparam logic [ST_W-1:0] S_RDHI = 4'd5;
    localparam logic [ST_W-1:0] S_RDLO = 4'd6;
    localparam logic [ST_W-1:0] S_WRHI = 4'd7;
    localparam logic [ST_W-1:0] S_WRLO = 4'd8;
    localparam logic [ST_W-1:0] S_PRD  = 4'd9;
    localparam logic [ST_W-1:0] S_PMAP = 4'd10;
    localparam logic [ST_W-1:0] S_PWR  = 4'd11;
    localparam logic [ST_W-1:0] S_ERD  = 4'd12;
    localparam logic [ST_W-1:0] S_ELD  = 4'd13;
    localparam logic [ST_W-1:0] S_EOUT = 4'd14;

    logic [ST_W-1:0]      state_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 ovf_reg;
    addr_t                idx_reg;
    addr_t                hi_reg;
    addr_t                rem_reg;
    addr_t                tmp_hi_reg;
    lcg_t                 lcg_reg;
    lcg_t                 prod_reg;
    lcg_t                 div_q_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    lcg_t                 seed_reg;
    logic                 mode_reg;
    logic                 out_valid_reg;
    byte_t                out_data_reg;
    logic                 out_last_reg;
    logic                 out_ovf_reg;

    byte_t in_mem   [STORE_DEPTH];
    addr_t perm_mem [STORE_DEPTH];
    byte_t out_mem  [STORE_DEPTH];

    byte_t in_rdata_reg;
    addr_t perm_rdata_reg;
    byte_t out_rdata_reg;

    logic  in_we;
    addr_t in_waddr;
    addr_t in_raddr;
    logic  perm_we;
    addr_t perm_waddr;
    addr_t perm_wdata;
    addr_t perm_raddr;
    logic  out_we;
    addr_t out_waddr;
    byte_t out_wdata;
    addr_t out_raddr;

    logic             s_fire;
    logic             room;
    logic             last_elem;
    logic [DIV_W-1:0] divisor;
    logic [DIV_W-1:0] trial;
    lcg_t             lcg_sum;

    assign s_axis_tready = (state_reg == S_LOAD);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign room          = (count_reg < CNT_W'(MAX_LEN));
    assign last_elem     = (idx_reg == ADDR_W'(count_reg - CNT_W'(1)));
    assign divisor       = DIV_W'(hi_reg) + DIV_W'(1);
    assign trial         = {rem_reg, div_q_reg[LCG_W-1]};
    assign lcg_sum       = prod_reg + LCG_ADD;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ovf_reg;

    always_comb
    begin
        in_we      = s_fire && room;
        in_waddr   = count_reg[ADDR_W-1:0];
        in_raddr   = idx_reg;
        perm_we    = 1'b0;
        perm_waddr = idx_reg;
        perm_wdata = idx_reg;
        perm_raddr = idx_reg;
        out_we     = 1'b0;
        out_waddr  = idx_reg;
        out_wdata  = in_rdata_reg;
        out_raddr  = idx_reg;
        unique case (state_reg)
            S_INIT:
            begin
                perm_we = 1'b1;
            end
            S_RDHI:
            begin
                perm_raddr = hi_reg;
            end
            S_RDLO:
            begin
                perm_raddr = rem_reg;
            end
            S_WRHI:
            begin
                perm_we    = 1'b1;
                perm_waddr = hi_reg;
                perm_wdata = perm_rdata_reg;
            end
            S_WRLO:
            begin
                perm_we    = 1'b1;
                perm_waddr = rem_reg;
                perm_wdata = tmp_hi_reg;
            end
            S_PMAP:
            begin
                if (mode_reg == MODE_SCRAMBLE)
                begin
                    out_we    = 1'b1;
                    out_waddr = perm_rdata_reg;
                end
                else
                begin
                    in_raddr = perm_rdata_reg;
                end
            end
            S_PWR:
            begin
                out_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_we)
        begin
            in_mem[in_waddr] <= s_axis_tdata;
        end
        in_rdata_reg <= in_mem[in_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (perm_we)
        begin
            perm_mem[perm_waddr] <= perm_wdata;
        end
        perm_rdata_reg <= perm_mem[perm_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (out_we)
        begin
            out_mem[out_waddr] <= out_wdata;
        end
        out_rdata_reg <= out_mem[out_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            mode_reg <= MODE_SCRAMBLE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_SEED: seed_reg <= cfg_data;
                CFG_MODE: mode_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_MUL:
            begin
                prod_reg <= lcg_reg * LCG_MUL;
            end
            S_ADD:
            begin
                div_q_reg <= lcg_sum;
            end
            S_DIV:
            begin
                div_q_reg <= {div_q_reg[LCG_W-2:0], 1'b0};
            end
            S_RDLO:
            begin
                tmp_hi_reg <= perm_rdata_reg;
            end
            S_ELD:
            begin
                out_data_reg <= out_rdata_reg;
                out_last_reg <= last_elem;
                out_ovf_reg  <= ovf_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            hi_reg        <= '0;
            rem_reg       <= '0;
            lcg_reg       <= '0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg) inside
                S_LOAD:
                begin
                    if (s_fire)
                    begin
                        if (room)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_axis_tlast)
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_INIT;
                        end
                    end
                end
                S_INIT:
                begin
                    if (last_elem)
                    begin
                        lcg_reg <= (seed_reg == '0) ? LCG_W'(1) : seed_reg;
                        if (count_reg == CNT_W'(1))
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_PRD;
                        end
                        else
                        begin
                            hi_reg    <= ADDR_W'(count_reg - CNT_W'(1));
                            state_reg <= S_MUL;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_reg + ADDR_W'(1);
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    lcg_reg     <= lcg_sum;
                    rem_reg     <= '0;
                    bit_cnt_reg <= '0;
                    state_reg   <= S_DIV;
                end
                S_DIV:
                begin
                    if (trial >= divisor)
                    begin
                        rem_reg <= ADDR_W'(trial - divisor);
                    end
                    else
                    begin
                        rem_reg <= ADDR_W'(trial);
                    end
                    bit_cnt_reg <= bit_cnt_reg + BIT_CNT_W'(1);
                    if (bit_cnt_reg == BIT_CNT_W'(LCG_W - 1))
                    begin
                        state_reg <= S_RDHI;
                    end
                end
                S_RDHI:
                begin
                    state_reg <= S_RDLO;
                end
                S_RDLO:
                begin
                    state_reg <= S_WRHI;
                end
                S_WRHI:
                begin
                    state_reg <= S_WRLO;
                end
                S_WRLO:
                begin
                    if (hi_reg == ADDR_W'(1))
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_PRD;
                    end
                    else
                    begin
                        hi_reg    <= hi_reg - ADDR_W'(1);
                        state_reg <= S_MUL;
                    end
                end
                S_PRD:
                begin
                    state_reg <= S_PMAP;
                end
                S_PMAP, S_PWR:
                begin
                    if (state_reg == S_PMAP && mode_reg == MODE_UNSCRAMBLE)
                    begin
                        state_reg <= S_PWR;
                    end
                    else if (last_elem)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_ERD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + ADDR_W'(1);
                        state_reg <= S_PRD;
                    end
                end
                S_ERD:
                begin
                    state_reg <= S_ELD;
                end
                S_ELD:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_EOUT;
                end
                S_EOUT:
                begin
                    if (m_axis_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + ADDR_W'(1);
                            state_reg <= S_ERD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    `KSP_ASSERT_SAME(a_no_overlap, clk, rst_n, s_axis_tready, !m_axis_tvalid, "input taken while output pending")
    `KSP_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_LEN), "block count above limit")
    `KSP_ASSERT_SAME(a_ovf_full, clk, rst_n, ovf_reg, count_reg == CNT_W'(MAX_LEN), "overflow without full block")
    `KSP_ASSERT_SAME(a_rem_bound, clk, rst_n, state_reg == S_DIV, DIV_W'(rem_reg) < divisor, "remainder not below divisor")
    `KSP_ASSERT_NEXT(a_last_done, clk, rst_n, m_axis_tvalid && m_axis_tready && m_axis_tlast, count_reg == '0 && !ovf_reg, "block state not cleared")

endmodule

`default_nettype wire
